// ===== rtl/rdmt_pkg.sv =====
// Package for the reference-counted dedup map table.
// Holds sizes, codes, payload and memory entry types; no dependencies.
`timescale 1ns / 1ps

package rdmt_pkg;

   // Table geometry.
   localparam int PROFILE_COUNT  = 8;
   localparam int BUTTON_COUNT   = 16;
   localparam int REGISTRY_DEPTH = 64;
   localparam int MAP_DEPTH      = 128;

   // Derived widths: addresses, counts that can hold the depth, keys.
   localparam int MAP_AW  = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
   localparam int MAP_CW  = $clog2(MAP_DEPTH + 1);
   localparam int REG_AW  = (REGISTRY_DEPTH > 1) ? $clog2(REGISTRY_DEPTH) : 1;
   localparam int REG_CW  = $clog2(REGISTRY_DEPTH + 1);
   localparam int SCAN_CW = (MAP_CW > REG_CW) ? MAP_CW : REG_CW;
   localparam int KEY_W   = (PROFILE_COUNT * BUTTON_COUNT > 1) ?
                            $clog2(PROFILE_COUNT * BUTTON_COUNT) : 1;
   // A reference count never exceeds the number of mappings.
   localparam int REFS_W  = MAP_CW;

   // Fixed field widths of the result item.
   localparam int IMG_W = 7;
   localparam int MAPC_W = 8;

   typedef enum logic [1:0] {
      OP_SAVE   = 2'd0,
      OP_DELETE = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_BAD_ARG   = 3'd1,
      STATUS_NOT_FOUND = 3'd2,
      STATUS_REG_FULL  = 3'd3,
      STATUS_MAP_FULL  = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_MAP_SCAN,
      SEQ_MAP_DEC,
      SEQ_LOOK_SCAN,
      SEQ_SAVE_SCAN,
      SEQ_SAVE_DEC,
      SEQ_MAP_LAST_RD,
      SEQ_MAP_MOVE,
      SEQ_DROP_SCAN,
      SEQ_DROP_DEC,
      SEQ_REG_LAST_RD,
      SEQ_REG_MOVE,
      SEQ_RESP
   } state_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  profile;
      logic [7:0]  button;
      logic [31:0] content_crc;
      logic [31:0] byte_count;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        unchanged;
      logic        dedup_hit;
      logic        write_blob;
      logic        free_blob;
      logic [31:0] freed_crc;
      logic [31:0] found_crc;
      logic [31:0] found_size;
      logic [6:0]  image_count;
      logic [7:0]  mapping_count;
      logic [31:0] shared_bytes;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [31:0]      hash;
   } map_entry_type;

   typedef struct packed {
      logic [31:0]       hash;
      logic [31:0]       size;
      logic [REFS_W-1:0] refs;
   } reg_entry_type;

   typedef struct packed {
      logic              en;
      logic [REG_AW-1:0] addr;
      reg_entry_type     data;
   } reg_wr_type;

endpackage

// ===== rtl/rdmt_req_if.sv =====
// Request channel of the dedup map table: valid, ready and one request item.
// Depends on rdmt_pkg.
`timescale 1ns / 1ps

interface rdmt_req_if;
   import rdmt_pkg::*;

   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/rdmt_rsp_if.sv =====
// Response channel of the dedup map table: valid, ready and one result item.
// Depends on rdmt_pkg.
`timescale 1ns / 1ps

interface rdmt_rsp_if;
   import rdmt_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/refcounted_dedup_map_table.sv =====
// Top level of the reference-counted dedup map table: sequencer, mapping
// memory and shared scan compare. Depends on rdmt_pkg, rdmt_req_if,
// rdmt_rsp_if and rdmt_registry.
//
//  channel   direction  handshake      item
//  req_ch    in         valid/ready    op, profile, button, content_crc, byte_count
//  rsp_ch    out        valid/ready    status, flags, hashes, sizes, counts
//
// One item is handled at a time, with a linear search over the entries in use:
// the mapping search, then up to two registry searches, all through one shared
// comparator. A bad argument skips the searches and goes straight to the result.
// Reset is synchronous and clears only the state, the scan flag, the use counts
// and the saved-byte total; no clearing pass.
// While a result waits on rsp_ch, req_ch is not ready.
`timescale 1ns / 1ps

module refcounted_dedup_map_table (
   input logic      clock,
   input logic      reset,
   rdmt_req_if.sink   req_ch,
   rdmt_rsp_if.source rsp_ch
);
   import rdmt_pkg::*;

   state_type state_ff, state_in;

   // Latched request.
   logic [1:0]       op_ff, op_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [31:0]      crc_ff, crc_in;
   logic [31:0]      len_ff, len_in;

   // Scan state.
   logic [SCAN_CW-1:0] scan_cnt_ff, scan_cnt_in;
   logic               pend_ff, pend_in;

   // Search results.
   logic              m_found_ff, m_found_in;
   logic [MAP_AW-1:0] m_idx_ff, m_idx_in;
   logic [31:0]       m_hash_ff, m_hash_in;
   logic              r_found_ff, r_found_in;
   logic [REG_AW-1:0] r_idx_ff, r_idx_in;
   reg_entry_type     r_ent_ff, r_ent_in;

   // Table counts and running saved-byte total.
   logic [MAP_CW-1:0] map_used_ff, map_used_in;
   logic [REG_CW-1:0] reg_used_ff, reg_used_in;
   logic [31:0]       saved_ff, saved_in;

   // Result fields.
   status_type  status_ff, status_in;
   logic        unch_ff, unch_in;
   logic        hit_ff, hit_in;
   logic        wr_ff, wr_in;
   logic        fr_ff, fr_in;
   logic [31:0] freed_ff, freed_in;
   logic [31:0] fcrc_ff, fcrc_in;
   logic [31:0] fsize_ff, fsize_in;

   // Mapping memory.
   map_entry_type     map_mem [MAP_DEPTH];
   map_entry_type     map_rd_ff;
   logic [MAP_AW-1:0] map_raddr;
   logic              map_we;
   logic [MAP_AW-1:0] map_waddr;
   map_entry_type     map_wdata;

   // Registry memory.
   logic [REG_AW-1:0] reg_raddr;
   reg_entry_type     reg_rd;
   reg_wr_type        reg_wr;

   // Shared scan compare.
   logic [SCAN_CW-1:0] scan_used;
   logic [SCAN_CW-1:0] hit_idx;
   logic [31:0]        cmp_a, cmp_b;
   logic               scan_match, scan_done;
   logic               bad_arg;
   logic [REFS_W-1:0]  new_refs;

   rdmt_registry u_registry (
      .clock   (clock),
      .rd_addr (reg_raddr),
      .rd_data (reg_rd),
      .wr      (reg_wr)
   );

   // Mapping memory: one write, one registered read.
   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= map_wdata;
      end
      map_rd_ff <= map_mem[map_raddr];
   end

   // Argument check of the incoming item.
   always_comb begin
      bad_arg = (req_ch.payload.op != OP_SAVE && req_ch.payload.op != OP_DELETE &&
                 req_ch.payload.op != OP_LOOKUP) ||
                ({1'b0, req_ch.payload.profile} >= 9'(PROFILE_COUNT)) ||
                ({1'b0, req_ch.payload.button} >= 9'(BUTTON_COUNT)) ||
                (req_ch.payload.op == OP_SAVE && req_ch.payload.byte_count == 32'd0);
   end

   // The comparator is shared by the mapping search and every registry search.
   always_comb begin
      scan_used  = (state_ff == SEQ_MAP_SCAN) ? SCAN_CW'(map_used_ff) : SCAN_CW'(reg_used_ff);
      cmp_a      = (state_ff == SEQ_MAP_SCAN) ? 32'(key_ff) :
                   (state_ff == SEQ_SAVE_SCAN) ? crc_ff : m_hash_ff;
      cmp_b      = (state_ff == SEQ_MAP_SCAN) ? 32'(map_rd_ff.key) : reg_rd.hash;
      scan_match = pend_ff && (cmp_a == cmp_b);
      scan_done  = scan_match || (scan_cnt_ff >= scan_used);
      hit_idx    = scan_cnt_ff - SCAN_CW'(1);
      new_refs   = (r_ent_ff.refs == '0) ? '0 : r_ent_ff.refs - REFS_W'(1);
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= SEQ_IDLE;
         map_used_ff <= '0;
         reg_used_ff <= '0;
         saved_ff    <= '0;
         pend_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         map_used_ff <= map_used_in;
         reg_used_ff <= reg_used_in;
         saved_ff    <= saved_in;
         pend_ff     <= pend_in;
      end
      op_ff       <= op_in;
      key_ff      <= key_in;
      crc_ff      <= crc_in;
      len_ff      <= len_in;
      scan_cnt_ff <= scan_cnt_in;
      m_found_ff  <= m_found_in;
      m_idx_ff    <= m_idx_in;
      m_hash_ff   <= m_hash_in;
      r_found_ff  <= r_found_in;
      r_idx_ff    <= r_idx_in;
      r_ent_ff    <= r_ent_in;
      status_ff   <= status_in;
      unch_ff     <= unch_in;
      hit_ff      <= hit_in;
      wr_ff       <= wr_in;
      fr_ff       <= fr_in;
      freed_ff    <= freed_in;
      fcrc_ff     <= fcrc_in;
      fsize_ff    <= fsize_in;
   end

   // Sequencer: next state, memory ports and result fields.
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      crc_in      = crc_ff;
      len_in      = len_ff;
      scan_cnt_in = scan_cnt_ff;
      pend_in     = pend_ff;
      m_found_in  = m_found_ff;
      m_idx_in    = m_idx_ff;
      m_hash_in   = m_hash_ff;
      r_found_in  = r_found_ff;
      r_idx_in    = r_idx_ff;
      r_ent_in    = r_ent_ff;
      map_used_in = map_used_ff;
      reg_used_in = reg_used_ff;
      saved_in    = saved_ff;
      status_in   = status_ff;
      unch_in     = unch_ff;
      hit_in      = hit_ff;
      wr_in       = wr_ff;
      fr_in       = fr_ff;
      freed_in    = freed_ff;
      fcrc_in     = fcrc_ff;
      fsize_in    = fsize_ff;

      map_raddr   = scan_cnt_ff[MAP_AW-1:0];
      map_we      = 1'b0;
      map_waddr   = m_idx_ff;
      map_wdata   = map_rd_ff;
      reg_raddr   = scan_cnt_ff[REG_AW-1:0];
      reg_wr.en   = 1'b0;
      reg_wr.addr = r_idx_ff;
      reg_wr.data = r_ent_ff;

      req_ch.ready = (state_ff == SEQ_IDLE);
      rsp_ch.valid = (state_ff == SEQ_RESP);

      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_ch.valid) begin
               op_in       = req_ch.payload.op;
               key_in      = KEY_W'(int'(req_ch.payload.profile) * BUTTON_COUNT +
                                    int'(req_ch.payload.button));
               crc_in      = req_ch.payload.content_crc;
               len_in      = req_ch.payload.byte_count;
               status_in   = STATUS_OK;
               unch_in     = 1'b0;
               hit_in      = 1'b0;
               wr_in       = 1'b0;
               fr_in       = 1'b0;
               freed_in    = '0;
               fcrc_in     = '0;
               fsize_in    = '0;
               scan_cnt_in = '0;
               pend_in     = 1'b0;
               if (bad_arg) begin
                  status_in = STATUS_BAD_ARG;
                  state_in  = SEQ_RESP;
               end else begin
                  state_in = SEQ_MAP_SCAN;
               end
            end
         end

         // Linear search of the mappings for the key.
         SEQ_MAP_SCAN: begin
            if (scan_done) begin
               m_found_in = scan_match;
               m_idx_in   = hit_idx[MAP_AW-1:0];
               m_hash_in  = map_rd_ff.hash;
               state_in   = SEQ_MAP_DEC;
            end else begin
               scan_cnt_in = scan_cnt_ff + SCAN_CW'(1);
               pend_in     = 1'b1;
            end
         end

         SEQ_MAP_DEC: begin
            scan_cnt_in = '0;
            pend_in     = 1'b0;
            priority if (op_ff == OP_LOOKUP) begin
               if (m_found_ff) begin
                  state_in = SEQ_LOOK_SCAN;
               end else begin
                  status_in = STATUS_NOT_FOUND;
                  state_in  = SEQ_RESP;
               end
            end else if (op_ff == OP_DELETE) begin
               state_in = m_found_ff ? SEQ_MAP_LAST_RD : SEQ_RESP;
            end else begin
               if (m_found_ff && m_hash_ff == crc_ff) begin
                  unch_in  = 1'b1;
                  state_in = SEQ_RESP;
               end else begin
                  state_in = SEQ_SAVE_SCAN;
               end
            end
         end

         // Lookup: find the size of the mapped hash.
         SEQ_LOOK_SCAN: begin
            if (scan_done) begin
               fcrc_in  = m_hash_ff;
               fsize_in = scan_match ? reg_rd.size : 32'd0;
               state_in = SEQ_RESP;
            end else begin
               scan_cnt_in = scan_cnt_ff + SCAN_CW'(1);
               pend_in     = 1'b1;
            end
         end

         // Save: search the registry for the new hash.
         SEQ_SAVE_SCAN: begin
            if (scan_done) begin
               r_found_in = scan_match;
               r_idx_in   = hit_idx[REG_AW-1:0];
               r_ent_in   = reg_rd;
               state_in   = SEQ_SAVE_DEC;
            end else begin
               scan_cnt_in = scan_cnt_ff + SCAN_CW'(1);
               pend_in     = 1'b1;
            end
         end

         // Save: full checks, then register or count the hash and map the key.
         SEQ_SAVE_DEC: begin
            scan_cnt_in = '0;
            pend_in     = 1'b0;
            priority if (!r_found_ff && reg_used_ff >= REG_CW'(REGISTRY_DEPTH)) begin
               status_in = STATUS_REG_FULL;
               state_in  = SEQ_RESP;
            end else if (!m_found_ff && map_used_ff >= MAP_CW'(MAP_DEPTH)) begin
               status_in = STATUS_MAP_FULL;
               state_in  = SEQ_RESP;
            end else begin
               reg_wr.en = 1'b1;
               if (r_found_ff) begin
                  reg_wr.addr      = r_idx_ff;
                  reg_wr.data      = r_ent_ff;
                  reg_wr.data.refs = r_ent_ff.refs + REFS_W'(1);
                  saved_in         = saved_ff + r_ent_ff.size;
                  hit_in           = 1'b1;
               end else begin
                  reg_wr.addr      = reg_used_ff[REG_AW-1:0];
                  reg_wr.data.hash = crc_ff;
                  reg_wr.data.size = len_ff;
                  reg_wr.data.refs = REFS_W'(1);
                  reg_used_in      = reg_used_ff + REG_CW'(1);
                  wr_in            = 1'b1;
               end
               map_we         = 1'b1;
               map_wdata.key  = key_ff;
               map_wdata.hash = crc_ff;
               if (m_found_ff) begin
                  map_waddr = m_idx_ff;
                  state_in  = SEQ_DROP_SCAN;
               end else begin
                  map_waddr   = map_used_ff[MAP_AW-1:0];
                  map_used_in = map_used_ff + MAP_CW'(1);
                  state_in    = SEQ_RESP;
               end
            end
         end

         // Delete: move the last mapping into the freed slot.
         SEQ_MAP_LAST_RD: begin
            map_raddr = MAP_AW'(map_used_ff - MAP_CW'(1));
            state_in  = SEQ_MAP_MOVE;
         end

         SEQ_MAP_MOVE: begin
            map_we      = 1'b1;
            map_waddr   = m_idx_ff;
            map_wdata   = map_rd_ff;
            map_used_in = map_used_ff - MAP_CW'(1);
            scan_cnt_in = '0;
            pend_in     = 1'b0;
            state_in    = SEQ_DROP_SCAN;
         end

         // Release of the old hash: search the registry.
         SEQ_DROP_SCAN: begin
            if (scan_done) begin
               r_found_in = scan_match;
               r_idx_in   = hit_idx[REG_AW-1:0];
               r_ent_in   = reg_rd;
               state_in   = SEQ_DROP_DEC;
            end else begin
               scan_cnt_in = scan_cnt_ff + SCAN_CW'(1);
               pend_in     = 1'b1;
            end
         end

         SEQ_DROP_DEC: begin
            priority if (!r_found_ff) begin
               state_in = SEQ_RESP;
            end else if (new_refs != '0) begin
               reg_wr.en        = 1'b1;
               reg_wr.addr      = r_idx_ff;
               reg_wr.data      = r_ent_ff;
               reg_wr.data.refs = new_refs;
               saved_in         = saved_ff - r_ent_ff.size;
               state_in         = SEQ_RESP;
            end else begin
               state_in = SEQ_REG_LAST_RD;
            end
         end

         // Last reference gone: move the last registry entry into its slot.
         SEQ_REG_LAST_RD: begin
            reg_raddr = REG_AW'(reg_used_ff - REG_CW'(1));
            state_in  = SEQ_REG_MOVE;
         end

         SEQ_REG_MOVE: begin
            reg_wr.en   = 1'b1;
            reg_wr.addr = r_idx_ff;
            reg_wr.data = reg_rd;
            reg_used_in = reg_used_ff - REG_CW'(1);
            fr_in       = 1'b1;
            freed_in    = m_hash_ff;
            state_in    = SEQ_RESP;
         end

         SEQ_RESP: begin
            if (rsp_ch.ready) begin
               state_in = SEQ_IDLE;
            end
         end

         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // Result item.
   always_comb begin
      rsp_ch.payload.status        = status_ff;
      rsp_ch.payload.unchanged     = unch_ff;
      rsp_ch.payload.dedup_hit     = hit_ff;
      rsp_ch.payload.write_blob    = wr_ff;
      rsp_ch.payload.free_blob     = fr_ff;
      rsp_ch.payload.freed_crc     = freed_ff;
      rsp_ch.payload.found_crc     = fcrc_ff;
      rsp_ch.payload.found_size    = fsize_ff;
      rsp_ch.payload.image_count   = IMG_W'(reg_used_ff);
      rsp_ch.payload.mapping_count = MAPC_W'(map_used_ff);
      rsp_ch.payload.shared_bytes  = saved_ff;
   end

   // Checks.
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("request taken while a result is pending");

   a_map_bound: assert property (@(posedge clock) disable iff (reset)
      map_used_ff <= MAP_CW'(MAP_DEPTH))
      else $error("mapping count beyond depth");

   a_reg_bound: assert property (@(posedge clock) disable iff (reset)
      reg_used_ff <= REG_CW'(REGISTRY_DEPTH))
      else $error("registry count beyond depth");

   a_hit_or_write: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !(hit_ff && wr_ff))
      else $error("dedup hit and blob write on the same item");
endmodule

// ===== rtl/rdmt_registry.sv =====
// Registry memory of unique hashes: hash, size and reference count per entry.
// One write and one registered read per cycle. Depends on rdmt_pkg.
`timescale 1ns / 1ps

module rdmt_registry (
   input  logic                        clock,
   input  logic [rdmt_pkg::REG_AW-1:0] rd_addr,
   output rdmt_pkg::reg_entry_type     rd_data,
   input  rdmt_pkg::reg_wr_type        wr
);
   import rdmt_pkg::*;

   reg_entry_type mem [REGISTRY_DEPTH];
   reg_entry_type rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
